FILE: design/qapsd_pkg.sv
// Shared types and constants of the quadratic assignment swap delta engine.
`timescale 1ns / 1ps
package qapsd_pkg;

	localparam int DEF_MAX_SIZE   = 64;
	localparam int DEF_ENTRY_BITS = 16;

	localparam int OP_W     = 3;
	localparam int IDX_IN_W = 6;
	localparam int VAL_IN_W = 16;
	localparam int RES_W    = 48;
	localparam int CFG_W    = 7;

	typedef enum logic [OP_W-1:0] {
		OP_WR_FLOW = 3'd0,
		OP_WR_DIST = 3'd1,
		OP_WR_ASG  = 3'd2,
		OP_DELTA   = 3'd3,
		OP_COMMIT  = 3'd4,
		OP_FULL    = 3'd5
	} qapsd_op_t;

	typedef enum logic [2:0] {
		T_RR,
		T_RS,
		T_K1,
		T_K2,
		T_FULL
	} qapsd_term_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_EXEC,
		S_PR,
		S_PS,
		S_PSL,
		S_CW1,
		S_CW2,
		S_KCHK,
		S_KL,
		S_ICHK,
		S_IL,
		S_JCHK,
		S_JL,
		S_TA,
		S_TB,
		S_TC,
		S_MUL,
		S_ACC,
		S_DONE
	} qapsd_state_t;

endpackage

FILE: design/qapsd_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module qapsd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/qap_swap_delta_engine_top.sv
// Top level of the quadratic assignment swap delta engine.
// One request at a time. A swap delta reads the flow, distance and assignment RAMs
// through one read port each and works term by term: two reads, a subtract, a
// multiply and an accumulate per term, two terms per position. A full cost reads,
// multiplies and accumulates one matrix cell at a time, with no subtract.
// A new request is taken while the previous result still waits in the output register.
`timescale 1ns / 1ps
module qap_swap_delta_engine_top #(
	parameter int MAX_SIZE   = qapsd_pkg::DEF_MAX_SIZE,
	parameter int ENTRY_BITS = qapsd_pkg::DEF_ENTRY_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [1:0]                             paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [qapsd_pkg::OP_W-1:0]             operation,
	input  logic [qapsd_pkg::IDX_IN_W-1:0]         row_index,
	input  logic [qapsd_pkg::IDX_IN_W-1:0]         col_index,
	input  logic [qapsd_pkg::VAL_IN_W-1:0]         entry_value,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [qapsd_pkg::RES_W-1:0]     result_value,
	output logic                                   status
);
	import qapsd_pkg::*;

	localparam int IDX_W = $clog2(MAX_SIZE);
	localparam int CELLS = MAX_SIZE * MAX_SIZE;
	localparam int AW    = $clog2(CELLS);
	localparam int DW    = ENTRY_BITS + 1;
	localparam int PW    = 2 * DW;
	localparam int SIZE_RESET = (64 < MAX_SIZE) ? 64 : MAX_SIZE;
	localparam logic [32:0] VALUE_MASK = 33'((64'd1 << ENTRY_BITS) - 64'd1);

	function automatic logic [AW-1:0] cell_addr(input logic [IDX_W-1:0] i,
			input logic [IDX_W-1:0] j);
		cell_addr = AW'(AW'(i) * AW'(MAX_SIZE)) + AW'(j);
	endfunction

	qapsd_state_t state_q, state_d;
	qapsd_term_t  tsel_q, tsel_d;

	logic [CFG_W-1:0] size_q;
	qapsd_op_t        op_q;
	logic [IDX_W-1:0] r_q, s_q, pr_q, ps_q, pk_q, pj_q;
	logic [ENTRY_BITS-1:0] v_q, fa_q, dc_q;
	logic             err_q;
	logic [CFG_W-1:0] k_q, j_q;
	logic signed [DW-1:0] d1_q, d2_q;
	logic signed [PW-1:0] prod_q;
	logic signed [RES_W-1:0] prod_ext;
	logic [RES_W-1:0] acc_q;

	logic in_acc, cfg_wr, in_err;
	logic [CFG_W-1:0] row_w, col_w;

	logic                  f_we, d_we, a_we;
	logic [AW-1:0]         f_waddr, d_waddr, f_raddr, d_raddr;
	logic [ENTRY_BITS-1:0] f_rdata, d_rdata;
	logic [IDX_W-1:0]      a_waddr, a_wdata, a_raddr, a_rdata;

	qapsd_ram #(.WIDTH(ENTRY_BITS), .DEPTH(CELLS)) u_flow (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(v_q),
		.raddr(f_raddr), .rdata(f_rdata)
	);
	qapsd_ram #(.WIDTH(ENTRY_BITS), .DEPTH(CELLS)) u_dist (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(v_q),
		.raddr(d_raddr), .rdata(d_rdata)
	);
	qapsd_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SIZE)) u_asg (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.raddr(a_raddr), .rdata(a_rdata)
	);

	assign pready   = 1'b1;
	assign prdata   = (paddr == 2'd0) ? 32'(size_q) : 32'd0;
	assign cfg_wr   = psel && penable && pwrite;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign row_w    = CFG_W'(row_index);
	assign col_w    = CFG_W'(col_index);
	assign prod_ext = RES_W'(prod_q);

	always_comb begin
		unique case (qapsd_op_t'(operation))
			OP_WR_FLOW, OP_WR_DIST:
				in_err = (row_w >= size_q) || (col_w >= size_q)
					|| (33'(entry_value) > VALUE_MASK);
			OP_WR_ASG:
				in_err = (row_w >= size_q) || (entry_value >= VAL_IN_W'(size_q));
			OP_DELTA, OP_COMMIT:
				in_err = (row_w >= size_q) || (col_w >= size_q);
			OP_FULL:
				in_err = 1'b0;
			default:
				in_err = 1'b1;
		endcase
	end

	always_comb begin
		state_d = state_q;
		tsel_d  = tsel_q;
		f_we    = 1'b0;
		d_we    = 1'b0;
		a_we    = 1'b0;
		f_waddr = cell_addr(r_q, s_q);
		d_waddr = cell_addr(r_q, s_q);
		a_waddr = r_q;
		a_wdata = IDX_W'(v_q);
		a_raddr = r_q;
		f_raddr = cell_addr(r_q, r_q);
		d_raddr = cell_addr(ps_q, ps_q);
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
				if (!err_q) begin
					unique case (op_q)
						OP_WR_FLOW: f_we = 1'b1;
						OP_WR_DIST: d_we = 1'b1;
						OP_WR_ASG:  a_we = 1'b1;
						OP_DELTA, OP_COMMIT: state_d = S_PR;
						OP_FULL:    state_d = S_ICHK;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_PR: begin
				a_raddr = r_q;
				state_d = S_PS;
			end
			S_PS: begin
				a_raddr = s_q;
				state_d = S_PSL;
			end
			S_PSL: begin
				tsel_d  = T_RR;
				state_d = (op_q == OP_COMMIT) ? S_CW1 : S_TA;
			end
			S_CW1: begin
				a_we    = 1'b1;
				a_waddr = r_q;
				a_wdata = ps_q;
				state_d = S_CW2;
			end
			S_CW2: begin
				a_we    = 1'b1;
				a_waddr = s_q;
				a_wdata = pr_q;
				state_d = S_DONE;
			end
			S_KCHK: begin
				a_raddr = IDX_W'(k_q);
				if (k_q == size_q) begin
					state_d = S_DONE;
				end else if (IDX_W'(k_q) != r_q && IDX_W'(k_q) != s_q) begin
					state_d = S_KL;
				end
			end
			S_KL: begin
				tsel_d  = T_K1;
				state_d = S_TA;
			end
			S_ICHK: begin
				a_raddr = IDX_W'(k_q);
				state_d = (k_q == size_q) ? S_DONE : S_IL;
			end
			S_IL: begin
				state_d = S_JCHK;
			end
			S_JCHK: begin
				a_raddr = IDX_W'(j_q);
				state_d = (j_q == size_q) ? S_ICHK : S_JL;
			end
			S_JL: begin
				tsel_d  = T_FULL;
				state_d = S_TA;
			end
			S_TA: begin
				unique case (tsel_q)
					T_RR: begin
						f_raddr = cell_addr(r_q, r_q);
						d_raddr = cell_addr(ps_q, ps_q);
					end
					T_RS: begin
						f_raddr = cell_addr(r_q, s_q);
						d_raddr = cell_addr(ps_q, pr_q);
					end
					T_K1: begin
						f_raddr = cell_addr(IDX_W'(k_q), r_q);
						d_raddr = cell_addr(pk_q, ps_q);
					end
					T_K2: begin
						f_raddr = cell_addr(r_q, IDX_W'(k_q));
						d_raddr = cell_addr(ps_q, pk_q);
					end
					default: begin
						f_raddr = cell_addr(IDX_W'(k_q), IDX_W'(j_q));
						d_raddr = cell_addr(pk_q, pj_q);
					end
				endcase
				state_d = S_TB;
			end
			S_TB: begin
				unique case (tsel_q)
					T_RR: begin
						f_raddr = cell_addr(s_q, s_q);
						d_raddr = cell_addr(pr_q, pr_q);
					end
					T_RS: begin
						f_raddr = cell_addr(s_q, r_q);
						d_raddr = cell_addr(pr_q, ps_q);
					end
					T_K1: begin
						f_raddr = cell_addr(IDX_W'(k_q), s_q);
						d_raddr = cell_addr(pk_q, pr_q);
					end
					T_K2: begin
						f_raddr = cell_addr(s_q, IDX_W'(k_q));
						d_raddr = cell_addr(pr_q, pk_q);
					end
					default: begin
						f_raddr = cell_addr(r_q, r_q);
						d_raddr = cell_addr(ps_q, ps_q);
					end
				endcase
				state_d = (tsel_q == T_FULL) ? S_MUL : S_TC;
			end
			S_TC: begin
				state_d = S_MUL;
			end
			S_MUL: begin
				state_d = S_ACC;
			end
			S_ACC: begin
				unique case (tsel_q)
					T_RR: begin
						tsel_d  = T_RS;
						state_d = S_TA;
					end
					T_RS: state_d = S_KCHK;
					T_K1: begin
						tsel_d  = T_K2;
						state_d = S_TA;
					end
					T_K2: state_d = S_KCHK;
					default: state_d = S_JCHK;
				endcase
			end
			S_DONE: begin
				if (!out_valid || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			tsel_q    <= T_RR;
			size_q    <= CFG_W'(SIZE_RESET);
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			tsel_q  <= tsel_d;
			if (cfg_wr && pwdata[CFG_W-1:0] != '0
					&& 32'(pwdata[CFG_W-1:0]) <= 32'(MAX_SIZE)) begin
				size_q <= pwdata[CFG_W-1:0];
			end
			if (state_q == S_DONE && (!out_valid || !out_stall)) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= qapsd_op_t'(operation);
			r_q   <= IDX_W'(row_index);
			s_q   <= IDX_W'(col_index);
			v_q   <= ENTRY_BITS'(entry_value);
			err_q <= in_err;
			acc_q <= '0;
			k_q   <= '0;
		end
		unique case (state_q)
			S_PS:   pr_q <= a_rdata;
			S_PSL:  ps_q <= a_rdata;
			S_KCHK: if (k_q != size_q && IDX_W'(k_q) != r_q && IDX_W'(k_q) != s_q) begin
			        	k_q <= k_q;
			        end else if (k_q != size_q) begin
			        	k_q <= k_q + 1'b1;
			        end
			S_KL:   pk_q <= a_rdata;
			S_IL: begin
				pk_q <= a_rdata;
				j_q  <= '0;
			end
			S_JCHK: if (j_q == size_q) begin
			        	k_q <= k_q + 1'b1;
			        end
			S_JL:   pj_q <= a_rdata;
			S_TB: begin
				fa_q <= f_rdata;
				dc_q <= d_rdata;
				d1_q <= $signed({1'b0, f_rdata});
				d2_q <= $signed({1'b0, d_rdata});
			end
			S_TC: begin
				d1_q <= $signed({1'b0, fa_q}) - $signed({1'b0, f_rdata});
				d2_q <= $signed({1'b0, dc_q}) - $signed({1'b0, d_rdata});
			end
			S_MUL:  prod_q <= d1_q * d2_q;
			S_ACC: begin
				acc_q <= acc_q + prod_ext;
				if (tsel_q == T_K2) begin
					k_q <= k_q + 1'b1;
				end else if (tsel_q == T_FULL) begin
					j_q <= j_q + 1'b1;
				end
			end
			default: ;
		endcase
		if (state_q == S_DONE && (!out_valid || !out_stall)) begin
			result_value <= err_q ? '0 : $signed(acc_q);
			status       <= err_q;
		end
	end

endmodule

FILE: tb/sv/tb_qap_swap_delta_engine_top.sv
// Testbench for the QAP swap delta engine: directed table, then predictor-checked random requests.
`timescale 1ns / 1ps
module tb_qap_swap_delta_engine_top;
	import qapsd_pkg::*;

	localparam int N_MAX = 64;
	localparam int WATCHDOG_LIMIT = 50000;
	localparam logic [2:0] OP_BAD_A = 3'd6;
	localparam logic [2:0] OP_BAD_B = 3'd7;
	localparam logic [1:0] ADDR_SIZE = 2'd0;

	typedef struct {
		logic [2:0]  op;
		logic [5:0]  r;
		logic [5:0]  c;
		logic [15:0] v;
	} request_t;

	typedef struct {
		logic signed [RES_W-1:0] value;
		logic                    st;
	} outcome_t;

	typedef struct {
		int          size_first;
		logic [2:0]  op;
		logic [5:0]  r;
		logic [5:0]  c;
		logic [15:0] v;
		bit          typed;
		logic signed [RES_W-1:0] value;
		logic        st;
	} row_t;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0, in_stall;
	logic [OP_W-1:0] operation = '0;
	logic [IDX_IN_W-1:0] row_index = '0, col_index = '0;
	logic [VAL_IN_W-1:0] entry_value = '0;
	logic out_valid, out_stall = 0;
	logic signed [RES_W-1:0] result_value;
	logic status;

	qap_swap_delta_engine_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .row_index(row_index), .col_index(col_index),
		.entry_value(entry_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_value(result_value), .status(status)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// shadow of the engine
	logic [15:0] flow_m [N_MAX*N_MAX];
	logic [15:0] dist_m [N_MAX*N_MAX];
	logic [5:0]  loc_m  [N_MAX];
	bit flow_w [N_MAX*N_MAX];
	bit dist_w [N_MAX*N_MAX];
	bit loc_w  [N_MAX];
	int size_now = 64;

	outcome_t pending_results[$];
	int errors = 0, requests_sent = 0, results_seen = 0, deltas = 0, full_costs = 0;
	int tx_idle_pct = 0, rx_idle_pct = 0, quiet_cycles = 0;

	task automatic report(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
		errors++;
	endtask

	function automatic longint fv(int i, int j);
		return longint'(flow_m[i*N_MAX+j]);
	endfunction

	function automatic longint dv(int i, int j);
		return longint'(dist_m[i*N_MAX+j]);
	endfunction

	function automatic logic [RES_W-1:0] swap_change(int r, int s);
		longint acc;
		int pr, ps, pk;
		pr = loc_m[r];
		ps = loc_m[s];
		acc = (fv(r, r) - fv(s, s)) * (dv(ps, ps) - dv(pr, pr))
			+ (fv(r, s) - fv(s, r)) * (dv(ps, pr) - dv(pr, ps));
		for (int k = 0; k < size_now; k++) begin
			if (k == r || k == s)
				continue;
			pk = loc_m[k];
			acc += (fv(k, r) - fv(k, s)) * (dv(pk, ps) - dv(pk, pr))
				+ (fv(r, k) - fv(s, k)) * (dv(ps, pk) - dv(pr, pk));
		end
		return acc[RES_W-1:0];
	endfunction

	function automatic logic [RES_W-1:0] assignment_cost();
		longint acc;
		acc = 0;
		for (int i = 0; i < size_now; i++)
			for (int j = 0; j < size_now; j++)
				acc += fv(i, j) * dv(loc_m[i], loc_m[j]);
		return acc[RES_W-1:0];
	endfunction

	task automatic predict_result(request_t q, output outcome_t o);
		int n, idx;
		logic [5:0] t;
		n = size_now;
		o.value = '0;
		o.st = 0;
		idx = q.r * N_MAX + q.c;
		case (q.op)
			OP_WR_FLOW, OP_WR_DIST: begin
				if (q.r >= n || q.c >= n)
					o.st = 1;
				else if (q.op == OP_WR_FLOW) begin
					flow_m[idx] = q.v;
					flow_w[idx] = 1;
				end else begin
					dist_m[idx] = q.v;
					dist_w[idx] = 1;
				end
			end
			OP_WR_ASG: begin
				if (q.r >= n || q.v >= n)
					o.st = 1;
				else begin
					loc_m[q.r] = q.v[5:0];
					loc_w[q.r] = 1;
				end
			end
			OP_DELTA: begin
				if (q.r >= n || q.c >= n)
					o.st = 1;
				else
					o.value = swap_change(q.r, q.c);
			end
			OP_COMMIT: begin
				if (q.r >= n || q.c >= n)
					o.st = 1;
				else begin
					t = loc_m[q.r];
					loc_m[q.r] = loc_m[q.c];
					loc_m[q.c] = t;
				end
			end
			OP_FULL: o.value = assignment_cost();
			default: o.st = 1;
		endcase
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	// substitute a write for a read of a store entry not yet written
	task automatic need_flow(int i, int j, inout bit hit, inout request_t q);
		if (hit || flow_w[i*N_MAX+j])
			return;
		hit = 1;
		q = '{OP_WR_FLOW, 6'(i), 6'(j), pick_value()};
	endtask

	task automatic need_dist(int x, int y, inout bit hit, inout request_t q);
		int a, b;
		a = loc_m[x];
		b = loc_m[y];
		if (hit || dist_w[a*N_MAX+b])
			return;
		hit = 1;
		if (a < size_now && b < size_now)
			q = '{OP_WR_DIST, 6'(a), 6'(b), pick_value()};
		else
			q = '{OP_WR_ASG, 6'(a >= size_now ? x : y), 6'($urandom_range(63)),
				16'($urandom_range(size_now - 1))};
	endtask

	task automatic fill_gaps(inout request_t q);
		bit hit;
		int r, s;
		hit = 0;
		r = q.r;
		s = q.c;
		if (q.op == OP_COMMIT) begin
			foreach (loc_w[k])
				if (!hit && (k == r || k == s) && !loc_w[k]) begin
					hit = 1;
					q = '{OP_WR_ASG, 6'(k), 6'($urandom_range(63)),
						16'($urandom_range(size_now - 1))};
				end
			return;
		end
		for (int k = 0; k < size_now && !hit; k++)
			if (!loc_w[k]) begin
				hit = 1;
				q = '{OP_WR_ASG, 6'(k), 6'($urandom_range(63)),
					16'($urandom_range(size_now - 1))};
			end
		if (q.op == OP_FULL) begin
			for (int i = 0; i < size_now; i++)
				for (int j = 0; j < size_now; j++) begin
					need_flow(i, j, hit, q);
					need_dist(i, j, hit, q);
				end
		end else if (q.op == OP_DELTA) begin
			for (int k = 0; k < size_now; k++) begin
				need_flow(k, r, hit, q);
				need_flow(k, s, hit, q);
				need_flow(r, k, hit, q);
				need_flow(s, k, hit, q);
				need_dist(k, s, hit, q);
				need_dist(k, r, hit, q);
				need_dist(s, k, hit, q);
				need_dist(r, k, hit, q);
			end
		end
	endtask

	task automatic random_request(int focus, output request_t q);
		int n, roll, span;
		n = size_now;
		span = (focus < n) ? focus : n;
		roll = $urandom_range(99);
		q = '{OP_WR_FLOW, 6'($urandom_range(n - 1)), 6'($urandom_range(n - 1)), pick_value()};
		if (roll < 5) begin
			case ($urandom_range(3))
				0: q = '{($urandom_range(1) ? OP_BAD_A : OP_BAD_B), 6'($urandom),
					6'($urandom), 16'($urandom)};
				1: if (n < N_MAX) q.r = 6'($urandom_range(63, n));
					else q.op = OP_BAD_A;
				2: begin
					q.op = OP_WR_ASG;
					q.v = 16'($urandom_range(65535, n));
				end
				default: begin
					q.op = $urandom_range(1) ? OP_DELTA : OP_COMMIT;
					if (n < N_MAX) q.c = 6'($urandom_range(63, n));
					else q.op = OP_BAD_B;
				end
			endcase
			return;
		end
		if (roll < 28)
			q.op = OP_WR_FLOW;
		else if (roll < 50)
			q.op = OP_WR_DIST;
		else if (roll < 58) begin
			q.op = OP_WR_ASG;
			q.v = 16'($urandom_range(n - 1));
		end else if (roll < 92 || n > 8) begin
			q.op = (roll < 82 || n > 8) ? OP_DELTA : OP_COMMIT;
			q.r = 6'($urandom_range(span - 1));
			q.c = 6'($urandom_range(span - 1));
		end else
			q.op = OP_FULL;
		if (q.op == OP_DELTA || q.op == OP_COMMIT || q.op == OP_FULL)
			fill_gaps(q);
	endtask

	// called right after a posedge; returns at the posedge that takes the request
	task automatic send_request(request_t q, bit typed, outcome_t want);
		outcome_t o;
		int gap;
		predict_result(q, o);
		pending_results.push_back(typed ? want : o);
		requests_sent++;
		if (q.op == OP_DELTA) deltas++;
		if (q.op == OP_FULL) full_costs++;
		gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(6, 1) : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		operation <= q.op;
		row_index <= q.r;
		col_index <= q.c;
		entry_value <= q.v;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_size(int value);
		drain();
		repeat (4) @(posedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= ADDR_SIZE;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		pwrite <= 0;
		penable <= 0;
		if ((value & 'h7F) >= 1 && (value & 'h7F) <= N_MAX)
			size_now = value & 'h7F;
		@(posedge clk);
		penable <= 1;
		@(negedge clk);
		if (prdata[CFG_W-1:0] !== CFG_W'(size_now))
			report("size_in_use readback", prdata[CFG_W-1:0], size_now);
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		@(posedge clk);
	endtask

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < rx_idle_pct);

	always @(negedge clk) begin
		outcome_t e;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			results_seen++;
			if (pending_results.size() == 0)
				report("result with no request waiting", result_value, 0);
			else begin
				e = pending_results.pop_front();
				if (result_value !== e.value)
					report("result_value", result_value, e.value);
				if (status !== e.st)
					report("status", status, e.st);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d results outstanding", pending_results.size());
				$display("tb_qap_swap_delta_engine_top: FAIL");
				$finish;
			end
		end
	end

	initial begin
		row_t steps [$];
		request_t q;
		outcome_t want;
		int sizes [7] = '{8, 3, 1, 5, 64, 2, 6};
		int counts [7] = '{100, 60, 40, 80, 650, 50, 70};
		int cfg_words [7] = '{8, 3, 1, 'h105, 64, 2, 6};

		steps = '{
			'{0, OP_BAD_A, 6'd63, 6'd63, 16'hFFFF, 1, 48'sd0, 1'b1},
			'{0, OP_BAD_B, 6'd0, 6'd0, 16'h0000, 1, 48'sd0, 1'b1},
			'{0, OP_WR_FLOW, 6'd63, 6'd63, 16'hFFFF, 1, 48'sd0, 1'b0},
			'{0, OP_WR_DIST, 6'd0, 6'd63, 16'h0000, 1, 48'sd0, 1'b0},
			'{0, OP_WR_ASG, 6'd63, 6'd0, 16'd63, 1, 48'sd0, 1'b0},
			'{0, OP_WR_ASG, 6'd0, 6'd63, 16'd0, 1, 48'sd0, 1'b0},
			'{0, OP_COMMIT, 6'd0, 6'd63, 16'hFFFF, 1, 48'sd0, 1'b0},
			'{1, OP_WR_FLOW, 6'd0, 6'd0, 16'hFFFF, 1, 48'sd0, 1'b0},
			'{0, OP_WR_DIST, 6'd0, 6'd0, 16'hFFFF, 1, 48'sd0, 1'b0},
			'{0, OP_WR_ASG, 6'd0, 6'd0, 16'd0, 1, 48'sd0, 1'b0},
			'{0, OP_FULL, 6'd63, 6'd63, 16'h1234, 1, 48'sd4294836225, 1'b0},
			'{0, OP_DELTA, 6'd0, 6'd0, 16'h0000, 1, 48'sd0, 1'b0},
			'{0, OP_COMMIT, 6'd0, 6'd0, 16'h0000, 1, 48'sd0, 1'b0},
			'{0, OP_WR_FLOW, 6'd1, 6'd0, 16'd5, 1, 48'sd0, 1'b1},
			'{0, OP_WR_DIST, 6'd0, 6'd63, 16'd5, 1, 48'sd0, 1'b1},
			'{0, OP_WR_ASG, 6'd0, 6'd0, 16'd1, 1, 48'sd0, 1'b1},
			'{0, OP_WR_ASG, 6'd1, 6'd0, 16'd0, 1, 48'sd0, 1'b1},
			'{0, OP_DELTA, 6'd0, 6'd1, 16'd0, 1, 48'sd0, 1'b1},
			'{0, OP_COMMIT, 6'd63, 6'd0, 16'd0, 1, 48'sd0, 1'b1},
			'{0, OP_FULL, 6'd0, 6'd0, 16'hFFFF, 0, 48'sd0, 1'b0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].size_first != 0) begin
				set_size(0);
				set_size(100);
				set_size(steps[i].size_first);
			end
			q = '{steps[i].op, steps[i].r, steps[i].c, steps[i].v};
			want = '{steps[i].value, steps[i].st};
			send_request(q, steps[i].typed, want);
		end

		foreach (sizes[p]) begin
			set_size(cfg_words[p]);
			tx_idle_pct = (p < 3) ? 15 : (p < 5) ? 78 : 0;
			rx_idle_pct = (p < 3) ? 78 : (p < 5) ? 15 : 0;
			for (int i = 0; i < counts[p]; i++) begin
				if (p == 1 && i == counts[p] / 2)
					drain();
				random_request(sizes[p] == 64 ? 2 : 64, q);
				send_request(q, 0, want);
			end
		end

		drain();
		repeat (100) @(posedge clk);
		$display("covered %0d requests (%0d swap deltas, %0d full costs), %0d results checked,",
			requests_sent, deltas, full_costs, results_seen);
		$display("sizes 1 to 64, bad opcodes, range errors and ignored register writes");
		if (errors == 0)
			$display("tb_qap_swap_delta_engine_top: PASS");
		else
			$display("tb_qap_swap_delta_engine_top: FAIL");
		$finish;
	end

endmodule
